/* src/mwm_pkg.sv */
// shared types and constants for the mecanum wheel mixer
package mwm_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int VEL_W      = 16;
    localparam int WHEEL_W    = 18;
    localparam int MAG_W      = 17;
    localparam int LIM_W      = 15;
    localparam int THR_W      = 10;
    localparam int QUO_W      = 15;
    localparam int SPEED_W    = 16;
    localparam int PROD1_W    = MAG_W + LIM_W;
    localparam int PROD2_W    = QUO_W + THR_W;
    localparam int CFG_DATA_W = 15;

    localparam logic [LIM_W-1:0] LIMIT_RESET  = 15'd10000;
    localparam logic [THR_W-1:0] THRESH_RESET = 10'd200;

    typedef enum logic {
        CFG_SPEED_LIMIT = 1'b0,
        CFG_BUF_THRESH  = 1'b1
    } t_cfg_reg;

    // carried alongside the speed-limit divider
    typedef struct packed {
        logic                                 scale;
        logic [NUM_WHEELS-1:0]                neg;
        logic [NUM_WHEELS-1:0][QUO_W-1:0]     mag;
        logic [THR_W-1:0]                     pbuf;
    } t_side1;

    // carried alongside the buffer derating divider
    typedef struct packed {
        logic                                 scale;
        logic [NUM_WHEELS-1:0]                neg;
        logic [NUM_WHEELS-1:0][QUO_W-1:0]     mag;
    } t_side2;

endpackage

/* src/mwm_kin.sv */
// wheel mixing, magnitude, peak search and speed-limit products (two stages)
module mwm_kin
    import mwm_pkg::*;
(
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [VEL_W-1:0]                i_vel_x,
    input  logic signed [VEL_W-1:0]                i_vel_y,
    input  logic signed [VEL_W-1:0]                i_vel_w,
    input  logic [THR_W-1:0]                       i_power_buffer,
    input  logic [LIM_W-1:0]                       i_speed_limit,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [NUM_WHEELS-1:0][PROD1_W-1:0]     o_num,
    output logic [MAG_W-1:0]                       o_den,
    output t_side1                                 o_side
);

    logic                              r_a_vld;
    logic [NUM_WHEELS-1:0][MAG_W-1:0]  r_a_mag;
    logic [NUM_WHEELS-1:0]             r_a_neg;
    logic [THR_W-1:0]                  r_a_pbuf;

    logic                              r_b_vld;
    logic [NUM_WHEELS-1:0][PROD1_W-1:0] r_b_num;
    logic [MAG_W-1:0]                  r_b_den;
    t_side1                            r_b_side;

    logic                              w_rdy_a;
    logic                              w_rdy_b;

    logic signed [WHEEL_W-1:0]         w_vx;
    logic signed [WHEEL_W-1:0]         w_vy;
    logic signed [WHEEL_W-1:0]         w_vw;
    logic signed [WHEEL_W-1:0]         w_whl [NUM_WHEELS];
    logic [NUM_WHEELS-1:0][MAG_W-1:0]  n_a_mag;
    logic [NUM_WHEELS-1:0]             n_a_neg;

    logic [MAG_W-1:0]                  w_max01;
    logic [MAG_W-1:0]                  w_max23;
    logic [MAG_W-1:0]                  n_b_den;
    logic [NUM_WHEELS-1:0][PROD1_W-1:0] n_b_num;
    t_side1                            n_b_side;

    assign w_rdy_b = !r_b_vld || i_ready;
    assign w_rdy_a = !r_a_vld || w_rdy_b;
    assign o_ready = w_rdy_a;

    assign w_vx = {{(WHEEL_W-VEL_W){i_vel_x[VEL_W-1]}}, i_vel_x};
    assign w_vy = {{(WHEEL_W-VEL_W){i_vel_y[VEL_W-1]}}, i_vel_y};
    assign w_vw = {{(WHEEL_W-VEL_W){i_vel_w[VEL_W-1]}}, i_vel_w};

    assign w_whl[0] =  w_vx - w_vy + w_vw;
    assign w_whl[1] = -w_vx - w_vy + w_vw;
    assign w_whl[2] = -w_vx + w_vy + w_vw;
    assign w_whl[3] =  w_vx + w_vy + w_vw;

    always_comb begin
        for (int l = 0; l < NUM_WHEELS; l++) begin
            n_a_neg[l] = w_whl[l][WHEEL_W-1];
            n_a_mag[l] = n_a_neg[l] ? MAG_W'(-w_whl[l]) : MAG_W'(w_whl[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_rdy_a) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_mag  <= n_a_mag;
            r_a_neg  <= n_a_neg;
            r_a_pbuf <= i_power_buffer;
        end
    end

    // peak magnitude and the products for the speed-limit scaling
    assign w_max01 = (r_a_mag[0] > r_a_mag[1]) ? r_a_mag[0] : r_a_mag[1];
    assign w_max23 = (r_a_mag[2] > r_a_mag[3]) ? r_a_mag[2] : r_a_mag[3];
    assign n_b_den = (w_max01 > w_max23) ? w_max01 : w_max23;

    always_comb begin
        n_b_side.scale = n_b_den > MAG_W'(i_speed_limit);
        n_b_side.neg   = r_a_neg;
        n_b_side.pbuf  = r_a_pbuf;
        for (int l = 0; l < NUM_WHEELS; l++) begin
            n_b_num[l]      = PROD1_W'(r_a_mag[l]) * PROD1_W'(i_speed_limit);
            n_b_side.mag[l] = r_a_mag[l][QUO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_rdy_b) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_b) begin
            r_b_num  <= n_b_num;
            r_b_den  <= n_b_den;
            r_b_side <= n_b_side;
        end
    end

    assign o_valid = r_b_vld;
    assign o_num   = r_b_num;
    assign o_den   = r_b_den;
    assign o_side  = r_b_side;

endmodule

/* src/mwm_div.sv */
// pipelined restoring divider, four lanes sharing one divisor, one quotient bit per stage
module mwm_div
    import mwm_pkg::*;
#(
    parameter int D_W    = 17,
    parameter int Q_W    = 15,
    parameter int SIDE_W = 8
)
(
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [NUM_WHEELS-1:0][D_W+Q_W-1:0]     i_num,
    input  logic [D_W-1:0]                         i_den,
    input  logic [SIDE_W-1:0]                      i_side,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [NUM_WHEELS-1:0][Q_W-1:0]         o_quo,
    output logic [SIDE_W-1:0]                      o_side
);

    // the quotient must fit Q_W bits, so the top D_W dividend bits start below the divisor
    logic                               r_vld  [Q_W+1];
    logic [NUM_WHEELS-1:0][D_W-1:0]     r_rem  [Q_W+1];
    logic [NUM_WHEELS-1:0][Q_W-1:0]     r_quo  [Q_W+1];
    logic [D_W-1:0]                     r_den  [Q_W+1];
    logic [SIDE_W-1:0]                  r_side [Q_W+1];

    wire                                n_vld  [Q_W+1];
    wire  [NUM_WHEELS-1:0][D_W-1:0]     n_rem  [Q_W+1];
    wire  [NUM_WHEELS-1:0][Q_W-1:0]     n_quo  [Q_W+1];
    wire  [D_W-1:0]                     n_den  [Q_W+1];
    wire  [SIDE_W-1:0]                  n_side [Q_W+1];
    wire                                w_rdy  [Q_W+2];

    assign w_rdy[Q_W+1] = i_ready;

    assign n_vld[0]  = i_valid;
    assign n_den[0]  = i_den;
    assign n_side[0] = i_side;

    genvar k, l;
    generate
        for (l = 0; l < NUM_WHEELS; l++) begin : g_load
            assign n_rem[0][l] = i_num[l][D_W+Q_W-1:Q_W];
            assign n_quo[0][l] = i_num[l][Q_W-1:0];
        end

        for (k = 1; k <= Q_W; k++) begin : g_step
            assign n_vld[k]  = r_vld[k-1];
            assign n_den[k]  = r_den[k-1];
            assign n_side[k] = r_side[k-1];
            for (l = 0; l < NUM_WHEELS; l++) begin : g_lane
                wire [D_W:0] w_t;
                wire         w_ge;
                // shift in the next dividend bit, subtract if it goes
                assign w_t  = {r_rem[k-1][l], r_quo[k-1][l][Q_W-1]};
                assign w_ge = w_t >= {1'b0, r_den[k-1]};
                assign n_rem[k][l] = w_ge ? D_W'(w_t - {1'b0, r_den[k-1]}) : w_t[D_W-1:0];
                assign n_quo[k][l] = {r_quo[k-1][l][Q_W-2:0], w_ge};
            end
        end

        for (k = 0; k <= Q_W; k++) begin : g_reg
            assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[k]) begin
                    r_rem[k]  <= n_rem[k];
                    r_quo[k]  <= n_quo[k];
                    r_den[k]  <= n_den[k];
                    r_side[k] <= n_side[k];
                end
            end
        end
    endgenerate

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[Q_W];
    assign o_quo   = r_quo[Q_W];
    assign o_side  = r_side[Q_W];

endmodule

/* src/mwm_derate.sv */
// picks limited or raw magnitudes and forms the buffer derating products
module mwm_derate
    import mwm_pkg::*;
(
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [NUM_WHEELS-1:0][QUO_W-1:0]       i_quo,
    input  t_side1                                 i_side,
    input  logic [THR_W-1:0]                       i_thr,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [NUM_WHEELS-1:0][PROD2_W-1:0]     o_num,
    output logic [THR_W-1:0]                       o_den,
    output t_side2                                 o_side
);

    logic                               r_vld;
    logic [NUM_WHEELS-1:0][PROD2_W-1:0] r_num;
    logic [THR_W-1:0]                   r_den;
    t_side2                             r_side;

    logic                               w_rdy;
    logic [NUM_WHEELS-1:0][PROD2_W-1:0] n_num;
    t_side2                             n_side;

    assign w_rdy   = !r_vld || i_ready;
    assign o_ready = w_rdy;

    always_comb begin
        n_side.scale = i_side.pbuf < i_thr;
        n_side.neg   = i_side.neg;
        for (int l = 0; l < NUM_WHEELS; l++) begin
            n_side.mag[l] = i_side.scale ? i_quo[l] : i_side.mag[l];
            n_num[l]      = PROD2_W'(n_side.mag[l]) * PROD2_W'(i_side.pbuf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_rdy) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_num  <= n_num;
            r_den  <= i_thr;
            r_side <= n_side;
        end
    end

    assign o_valid = r_vld;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

/* src/mecanum_wheel_mixer.sv */
// mecanum wheel mixer top level: config registers, pipeline chain and output register
// throughput: one command per cycle while the output is not stalled, set by the
// one-bit-per-stage pipelined dividers; an output stall backs up stage by stage,
// bubbles are squeezed out meanwhile; reset (synchronous, active low) empties the
// pipeline and loads speed_limit 10000 and buffer_threshold 200
module mecanum_wheel_mixer
    import mwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // vel_x, vel_y, vel_w, power_buffer, zero pad
    input  logic [63:0]             s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3
    output logic [63:0]             m_axis_tdata,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic [LIM_W-1:0]                   r_speed_limit;
    logic [THR_W-1:0]                   r_buf_thresh;

    logic                               w_kin_vld;
    logic                               w_kin_rdy;
    logic [NUM_WHEELS-1:0][PROD1_W-1:0] w_kin_num;
    logic [MAG_W-1:0]                   w_kin_den;
    t_side1                             w_kin_side;

    logic                               w_d1_vld;
    logic                               w_d1_rdy;
    logic [NUM_WHEELS-1:0][QUO_W-1:0]   w_d1_quo;
    logic [$bits(t_side1)-1:0]          w_d1_side;

    logic                               w_dr_vld;
    logic                               w_dr_rdy;
    logic [NUM_WHEELS-1:0][PROD2_W-1:0] w_dr_num;
    logic [THR_W-1:0]                   w_dr_den;
    t_side2                             w_dr_side;

    logic                               w_d2_vld;
    logic                               w_d2_rdy;
    logic [NUM_WHEELS-1:0][QUO_W-1:0]   w_d2_quo;
    logic [$bits(t_side2)-1:0]          w_d2_side;
    t_side2                             w_side2;

    logic                               r_out_vld;
    logic [63:0]                        r_out_data;
    logic [63:0]                        n_out_data;

    // configuration writes, always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit <= LIMIT_RESET;
            r_buf_thresh  <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[LIM_W-1:0];
                CFG_BUF_THRESH:  r_buf_thresh  <= i_cfg_data[THR_W-1:0];
            endcase
        end
    end

    mwm_kin u_kin (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_vel_x        (s_axis_tdata[15:0]),
        .i_vel_y        (s_axis_tdata[31:16]),
        .i_vel_w        (s_axis_tdata[47:32]),
        .i_power_buffer (s_axis_tdata[57:48]),
        .i_speed_limit  (r_speed_limit),
        .o_valid        (w_kin_vld),
        .i_ready        (w_kin_rdy),
        .o_num          (w_kin_num),
        .o_den          (w_kin_den),
        .o_side         (w_kin_side)
    );

    // speed limit: |w| * limit / peak
    mwm_div #(
        .D_W    (MAG_W),
        .Q_W    (QUO_W),
        .SIDE_W ($bits(t_side1))
    ) u_div_limit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_kin_vld),
        .o_ready (w_kin_rdy),
        .i_num   (w_kin_num),
        .i_den   (w_kin_den),
        .i_side  (w_kin_side),
        .o_valid (w_d1_vld),
        .i_ready (w_d1_rdy),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_side)
    );

    mwm_derate u_derate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d1_vld),
        .o_ready (w_d1_rdy),
        .i_quo   (w_d1_quo),
        .i_side  (t_side1'(w_d1_side)),
        .i_thr   (r_buf_thresh),
        .o_valid (w_dr_vld),
        .i_ready (w_dr_rdy),
        .o_num   (w_dr_num),
        .o_den   (w_dr_den),
        .o_side  (w_dr_side)
    );

    // buffer derating: |w| * buffer / threshold
    mwm_div #(
        .D_W    (THR_W),
        .Q_W    (QUO_W),
        .SIDE_W ($bits(t_side2))
    ) u_div_buffer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dr_vld),
        .o_ready (w_dr_rdy),
        .i_num   (w_dr_num),
        .i_den   (w_dr_den),
        .i_side  (w_dr_side),
        .o_valid (w_d2_vld),
        .i_ready (w_d2_rdy),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_side)
    );

    assign w_side2  = t_side2'(w_d2_side);
    assign w_d2_rdy = !r_out_vld || m_axis_tready;

    // restore the signs, truncation toward zero falls out of working on magnitudes
    always_comb begin
        logic [QUO_W-1:0] mag;
        for (int l = 0; l < NUM_WHEELS; l++) begin
            mag = w_side2.scale ? w_d2_quo[l] : w_side2.mag[l];
            n_out_data[l*SPEED_W +: SPEED_W] =
                w_side2.neg[l] ? SPEED_W'(-{1'b0, mag}) : {1'b0, mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_d2_rdy) begin
            r_out_vld <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d2_rdy) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

/* bench/mwm_speed_checker.sv */
// channel monitor for the mecanum wheel mixer: predicts wheel speeds per command and compares
`timescale 1ns / 1ps
module mwm_speed_checker
    import mwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    input  logic                    i_cmd_ready,
    input  logic [63:0]             i_cmd_data,
    input  logic                    i_wheel_valid,
    input  logic                    i_wheel_ready,
    input  logic [63:0]             i_wheel_data,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic                    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_wrap_up,
    output int                      o_outstanding,
    output int                      o_fail_count
);

    localparam int PRINT_CAP = 40;

    typedef logic [NUM_WHEELS-1:0][SPEED_W-1:0] t_speeds;

    logic [LIM_W-1:0] limit_q;
    logic [THR_W-1:0] thresh_q;
    t_speeds          pending_speeds[$];
    int               n_results;

    initial o_fail_count = 0;

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP) begin
            $display("error: %s", msg);
        end
        o_fail_count++;
    endtask

    // inverse kinematics, then speed-limit normalisation, then buffer derating
    function automatic t_speeds mix_wheels(input logic [63:0] cmd,
                                           input logic [LIM_W-1:0] lim,
                                           input logic [THR_W-1:0] thr);
        longint  vx, vy, vw, pbuf, peak, mag;
        longint  w[NUM_WHEELS];
        t_speeds speeds;
        vx   = longint'($signed(cmd[0 +: VEL_W]));
        vy   = longint'($signed(cmd[VEL_W +: VEL_W]));
        vw   = longint'($signed(cmd[2*VEL_W +: VEL_W]));
        pbuf = longint'(cmd[3*VEL_W +: THR_W]);
        w[0] =  vx - vy + vw;
        w[1] = -vx - vy + vw;
        w[2] = -vx + vy + vw;
        w[3] =  vx + vy + vw;
        peak = 0;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            mag = (w[i] < 0) ? -w[i] : w[i];
            if (mag > peak) begin
                peak = mag;
            end
        end
        if (peak > longint'(lim)) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                w[i] = (w[i] * longint'(lim)) / peak;
            end
        end
        // a zero threshold never derates
        if (pbuf < longint'(thr)) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                w[i] = (w[i] * pbuf) / longint'(thr);
            end
        end
        for (int i = 0; i < NUM_WHEELS; i++) begin
            speeds[i] = SPEED_W'(w[i]);
        end
        return speeds;
    endfunction

    always @(posedge i_clk) begin : watch
        t_speeds seen;
        t_speeds want;
        if (!i_rst_n) begin
            limit_q  = LIMIT_RESET;
            thresh_q = THRESH_RESET;
            pending_speeds.delete();
            n_results = 0;
        end else begin
            // results first, so a command accepted on the same edge cannot mask a stray one
            if (i_wheel_valid && i_wheel_ready) begin
                seen = i_wheel_data;
                if (pending_speeds.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no command waiting",
                                              n_results));
                end else begin
                    want = pending_speeds.pop_front();
                    for (int k = 0; k < NUM_WHEELS; k++) begin
                        if (seen[k] !== want[k]) begin
                            report_mismatch($sformatf("result %0d wheel %0d: got %0d, want %0d",
                                                      n_results, k, $signed(seen[k]),
                                                      $signed(want[k])));
                        end
                    end
                end
                n_results++;
            end
            if (i_cmd_valid && i_cmd_ready) begin
                pending_speeds.push_back(mix_wheels(i_cmd_data, limit_q, thresh_q));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_SPEED_LIMIT: limit_q  = i_cfg_data[LIM_W-1:0];
                    CFG_BUF_THRESH:  thresh_q = i_cfg_data[THR_W-1:0];
                endcase
            end
            if (i_wrap_up && pending_speeds.size() != 0) begin
                report_mismatch($sformatf("%0d results never arrived", pending_speeds.size()));
                pending_speeds.delete();
            end
        end
        o_outstanding <= pending_speeds.size();
    end

endmodule

/* bench/mecanum_wheel_mixer_tb.sv */
// top of the mecanum wheel mixer bench: clock, reset, command and register stimulus, verdict
`timescale 1ns / 1ps
module mecanum_wheel_mixer_tb;
    import mwm_pkg::*;

    localparam int CYCLE_LIMIT     = 200_000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 194;
    localparam int PAD_W           = 64 - 3 * VEL_W - THR_W;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_reg              i_cfg_index   = CFG_SPEED_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    logic                  wrap_up     = 1'b0;
    logic                  steady      = 1'b0;   // no idling on either side
    int                    outstanding;
    int                    fail_count;
    int                    cycle_count = 0;
    // register values as last written, used only to aim the random commands
    logic [LIM_W-1:0]      cur_limit   = LIMIT_RESET;
    logic [THR_W-1:0]      cur_thresh  = THRESH_RESET;

    mecanum_wheel_mixer u_top (
        .i_clk,
        .i_rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .i_cfg_valid,
        .o_cfg_ready,
        .i_cfg_index,
        .i_cfg_data
    );

    mwm_speed_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (s_axis_tvalid),
        .i_cmd_ready   (s_axis_tready),
        .i_cmd_data    (s_axis_tdata),
        .i_wheel_valid (m_axis_tvalid),
        .i_wheel_ready (m_axis_tready),
        .i_wheel_data  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_wrap_up     (wrap_up),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 32);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_command(input logic [VEL_W-1:0] vx, input logic [VEL_W-1:0] vy,
                                input logic [VEL_W-1:0] vw, input logic [THR_W-1:0] pbuf);
        while (!steady && $urandom_range(0, 99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, pbuf, vw, vy, vx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold off new commands until every expected result has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_registers(input logic [CFG_DATA_W-1:0] limit,
                                 input logic [CFG_DATA_W-1:0] thresh);
        wait_idle();
        write_reg(CFG_SPEED_LIMIT, limit);
        write_reg(CFG_BUF_THRESH, thresh);
        i_cfg_valid <= 1'b0;
        cur_limit  = limit[LIM_W-1:0];
        cur_thresh = thresh[THR_W-1:0];
    endtask

    // mix of extremes, values around the speed limit and full-range noise
    function automatic logic [VEL_W-1:0] pick_velocity();
        int span;
        span = int'(cur_limit) / 2 + 1;
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return VEL_W'(int'($urandom_range(0, 2 * span)) - span);
            default: return VEL_W'($urandom());
        endcase
    endfunction

    function automatic logic [THR_W-1:0] pick_buffer();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return THR_W'(int'(cur_thresh) - 2 + int'($urandom_range(0, 3)));
            default: return THR_W'($urandom());
        endcase
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values
        send_command(16'h0000, 16'h0000, 16'h0000, 10'd0);
        send_command(16'h7FFF, 16'h8000, 16'h7FFF, 10'd1023);
        send_command(16'h8000, 16'h7FFF, 16'h8000, 10'd1023);
        send_command(16'h7FFF, 16'h7FFF, 16'h7FFF, 10'd1023);
        send_command(16'h8000, 16'h8000, 16'h8000, 10'd0);
        send_command(16'd10000, 16'h0000, 16'h0000, 10'd500);  // peak exactly at the limit
        send_command(16'd10001, 16'h0000, 16'h0000, 10'd500);  // one over the limit
        send_command(16'd100, -16'sd200, 16'd300, 10'd199);    // buffer just under threshold
        send_command(16'd100, -16'sd200, 16'd300, 10'd200);    // buffer at threshold
        send_command(16'h8000, 16'h0000, 16'h0000, 10'd1);
        send_command(16'hFFFF, 16'h0001, 16'hFFFF, 10'd0);

        // zero limit flattens any motion, zero threshold never derates
        set_registers(15'd0, 15'd0);
        send_command(16'h0000, 16'h0000, 16'h0000, 10'd0);
        send_command(16'd1, 16'h0000, 16'h0000, 10'd0);
        send_command(16'h8000, 16'h7FFF, 16'h1234, 10'd1023);

        set_registers(15'h7FFF, 15'd1023);
        send_command(16'h7FFF, 16'h8000, 16'h7FFF, 10'd1022);
        send_command(16'h8000, 16'h8000, 16'h8000, 10'd1023);
        send_command(16'd20000, -16'sd5000, 16'd7000, 10'd512);

        set_registers(15'd1, 15'd1);
        send_command(16'd1, 16'h0000, 16'h0000, 10'd1);
        send_command(16'h0000, 16'h0001, 16'h0000, 10'd0);
        send_command(16'h7FFF, 16'h7FFF, 16'h8000, 10'd0);

        // bits above the threshold width are dropped
        set_registers(15'd3000, 15'h7C0A);
        send_command(16'd2000, 16'd1500, -16'sd700, 10'd9);
        send_command(16'd2000, 16'd1500, -16'sd700, 10'd10);
        send_command(-16'sd4000, 16'd123, 16'd4567, 10'd3);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       set_registers(CFG_DATA_W'(LIMIT_RESET), CFG_DATA_W'(THRESH_RESET));
                1:       set_registers(15'd0, 15'd0);
                2:       set_registers(15'h7FFF, 15'd1023);
                4:       set_registers(15'd1, 15'd1);
                5:       set_registers(CFG_DATA_W'($urandom_range(1, 32767)),
                                       CFG_DATA_W'($urandom_range(1, 1023)));
                6:       set_registers(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
                7:       set_registers(15'd5000, 15'd1023);
                default: set_registers(CFG_DATA_W'($urandom_range(1, 32767)),
                                       CFG_DATA_W'($urandom_range(1, 1023)));
            endcase
            steady = (p == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_command(pick_velocity(), pick_velocity(), pick_velocity(), pick_buffer());
            end
            steady = 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        wrap_up <= 1'b1;
        @(posedge i_clk);
        wrap_up <= 1'b0;
        @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
src/mwm_pkg.sv
src/mwm_kin.sv
src/mwm_div.sv
src/mwm_derate.sv
src/mecanum_wheel_mixer.sv
bench/mwm_speed_checker.sv
bench/mecanum_wheel_mixer_tb.sv
